@@ src/stl_pkg.sv @@
// Shared types and constants for the shell token lexer.
// Item structs, result bundle, character and code constants.
// No dependencies.
`default_nettype none

package stl_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PIPE  = 8'h7c;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;

    localparam logic [3:0] KIND_WORD       = 4'd0;
    localparam logic [3:0] KIND_SEP        = 4'd1;
    localparam logic [3:0] KIND_IN         = 4'd2;
    localparam logic [3:0] KIND_OUT        = 4'd3;
    localparam logic [3:0] KIND_APPEND     = 4'd4;
    localparam logic [3:0] KIND_ERR_OUT    = 4'd5;
    localparam logic [3:0] KIND_ERR_APPEND = 4'd6;
    localparam logic [3:0] KIND_DQUOTE     = 4'd7;
    localparam logic [3:0] KIND_SQUOTE     = 4'd8;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_SEP    = 2'd1;
    localparam logic [1:0] ERR_REDIR  = 2'd2;
    localparam logic [1:0] ERR_QUOTE  = 2'd3;

    localparam int MAX_RES = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [3:0] token_kind;
        logic       token_end;
        logic [1:0] error_code;
        logic       run_last;
    } out_item_t;

    // Results caused by one input item, in order; cnt is 0..4.
    typedef struct packed {
        logic [2:0]                  cnt;
        out_item_t [MAX_RES-1:0]     r;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

@@ src/stl_front.sv @@
// Front end of the shell token lexer: lexer state and classification.
// Turns each accepted byte into a bundle of up to four results.
// Depends on stl_pkg.
`default_nettype none

module stl_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  stl_pkg::in_item_t     item,
    output stl_pkg::bundle_t      bundle,
    output logic                  push
);
    import stl_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_TWO,
        MODE_OP,
        MODE_QUOTE,
        MODE_DROP
    } mode_t;

    typedef struct packed {
        mode_t           mode;
        logic [2:0][7:0] opc;
        logic [2:0]      oplen;
        logic            qc;
        logic [7:0]      hb;
        logic            hv;
    } lex_t;

    typedef struct packed {
        lex_t    st;
        bundle_t b;
        logic    ok;
    } step_t;

    lex_t lex_reg;
    lex_t lex_next;

    function automatic logic is_ws(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL;
    endfunction

    function automatic logic is_sepc(logic [7:0] c);
        return c == CH_SEMI || c == CH_AMP || c == CH_PIPE;
    endfunction

    function automatic logic is_redc(logic [7:0] c);
        return c == CH_LT || c == CH_GT;
    endfunction

    function automatic logic is_opc(logic [7:0] c);
        return c == CH_TWO || is_sepc(c) || is_redc(c);
    endfunction

    function automatic logic is_stop_c(logic [7:0] c);
        return is_ws(c) || is_sepc(c) || is_redc(c);
    endfunction

    function automatic bundle_t put(bundle_t b, logic [7:0] byt, logic has,
                                    logic [3:0] kind, logic endt, logic [1:0] err);
        out_item_t r;
        r.out_byte   = byt;
        r.has_byte   = has;
        r.token_kind = kind;
        r.token_end  = endt;
        r.error_code = err;
        r.run_last   = 1'b0;
        if (b.cnt < 3'd4) begin
            b.r[b.cnt[1:0]] = r;
            b.cnt = b.cnt + 3'd1;
        end
        return b;
    endfunction

    function automatic lex_t start_tok(lex_t s, logic [7:0] c);
        if (is_ws(c)) begin
            s.mode = MODE_IDLE;
        end else if (c == CH_DQ || c == CH_SQ) begin
            s.mode = MODE_QUOTE;
            s.qc   = (c == CH_SQ);
            s.hv   = 1'b0;
        end else if (c == CH_TWO) begin
            s.mode = MODE_TWO;
        end else if (is_opc(c)) begin
            s.mode   = MODE_OP;
            s.opc[0] = c;
            s.oplen  = 3'd1;
        end else begin
            s.mode = MODE_WORD;
            s.hb   = c;
        end
        return s;
    endfunction

    function automatic step_t word_feed(step_t x, logic [7:0] c);
        if (is_stop_c(c)) begin
            x.b  = put(x.b, x.st.hb, 1'b1, KIND_WORD, 1'b1, ERR_NONE);
            x.st = start_tok(x.st, c);
        end else begin
            x.b     = put(x.b, x.st.hb, 1'b1, KIND_WORD, 1'b0, ERR_NONE);
            x.st.hb = c;
        end
        return x;
    endfunction

    // Judge the finished run; emit its bytes or an error item.
    function automatic step_t resolve(step_t x);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [2:0] len;
        logic [3:0] kind;
        logic [1:0] err;
        a    = x.st.opc[0];
        b    = x.st.opc[1];
        c    = x.st.opc[2];
        len  = x.st.oplen;
        kind = KIND_WORD;
        err  = ERR_NONE;
        if (is_sepc(a)) begin
            if (len == 3'd1 && (a == CH_SEMI || a == CH_PIPE)) kind = KIND_SEP;
            else if (len == 3'd2 && a == CH_AMP && b == CH_AMP) kind = KIND_SEP;
            else err = ERR_SEP;
        end else begin
            if (len == 3'd1 && a == CH_LT) kind = KIND_IN;
            else if (len == 3'd2 && a == CH_LT && b == CH_LT) kind = KIND_IN;
            else if (len == 3'd1 && a == CH_GT) kind = KIND_OUT;
            else if (len == 3'd2 && a == CH_GT && b == CH_GT) kind = KIND_APPEND;
            else if (len == 3'd2 && a == CH_TWO && b == CH_GT) kind = KIND_ERR_OUT;
            else if (len == 3'd3 && a == CH_TWO && b == CH_GT && c == CH_GT)
                kind = KIND_ERR_APPEND;
            else err = ERR_REDIR;
        end
        x.st.oplen = 3'd0;
        if (err != ERR_NONE) begin
            x.b       = put(x.b, 8'd0, 1'b0, KIND_WORD, 1'b1, err);
            x.st.mode = MODE_DROP;
            x.ok      = 1'b0;
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (3'(i) < len)
                    x.b = put(x.b, x.st.opc[i], 1'b1, kind, 3'(i + 1) == len, ERR_NONE);
            end
            x.st.mode = MODE_IDLE;
            x.ok      = 1'b1;
        end
        return x;
    endfunction

    step_t      x;
    logic [7:0] ch;
    logic [3:0] qk;

    always_comb begin
        ch     = item.in_byte;
        qk     = lex_reg.qc ? KIND_SQUOTE : KIND_DQUOTE;
        x.st   = lex_reg;
        x.b    = '0;
        x.ok   = 1'b0;
        unique case (lex_reg.mode)
            MODE_WORD: begin
                x = word_feed(x, ch);
            end
            MODE_TWO: begin
                if (is_redc(ch)) begin
                    x.st.mode   = MODE_OP;
                    x.st.opc[0] = CH_TWO;
                    x.st.opc[1] = ch;
                    x.st.oplen  = 3'd2;
                end else begin
                    x.st.mode = MODE_WORD;
                    x.st.hb   = CH_TWO;
                    x = word_feed(x, ch);
                end
            end
            MODE_OP: begin
                if (is_opc(ch)) begin
                    if (lex_reg.oplen < 3'd3) x.st.opc[lex_reg.oplen[1:0]] = ch;
                    if (lex_reg.oplen < 3'd4) x.st.oplen = lex_reg.oplen + 3'd1;
                end else begin
                    x = resolve(x);
                    if (x.ok) x.st = start_tok(x.st, ch);
                end
            end
            MODE_QUOTE: begin
                if (ch == (lex_reg.qc ? CH_SQ : CH_DQ)) begin
                    if (lex_reg.hv)
                        x.b = put(x.b, lex_reg.hb, 1'b1, qk, 1'b1, ERR_NONE);
                    else
                        x.b = put(x.b, 8'd0, 1'b0, qk, 1'b1, ERR_NONE);
                    x.st.hv   = 1'b0;
                    x.st.mode = MODE_IDLE;
                end else begin
                    if (lex_reg.hv)
                        x.b = put(x.b, lex_reg.hb, 1'b1, qk, 1'b0, ERR_NONE);
                    x.st.hb = ch;
                    x.st.hv = 1'b1;
                end
            end
            MODE_DROP: begin
            end
            default: begin
                x.st = start_tok(x.st, ch);
            end
        endcase

        // Flush any pending token at end of line.
        if (item.line_end) begin
            case (x.st.mode)
                MODE_WORD:  x.b = put(x.b, x.st.hb, 1'b1, KIND_WORD, 1'b1, ERR_NONE);
                MODE_TWO:   x.b = put(x.b, CH_TWO, 1'b1, KIND_WORD, 1'b1, ERR_NONE);
                MODE_OP:    x = resolve(x);
                MODE_QUOTE: x.b = put(x.b, 8'd0, 1'b0, KIND_WORD, 1'b1, ERR_QUOTE);
                default:    ;
            endcase
            x.st.mode  = MODE_IDLE;
            x.st.oplen = 3'd0;
            x.st.hv    = 1'b0;
        end

        lex_next = x.st;
        bundle   = x.b;
        push     = accept && (x.b.cnt != 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lex_reg.mode  <= MODE_IDLE;
            lex_reg.oplen <= 3'd0;
            lex_reg.qc    <= 1'b0;
            lex_reg.hv    <= 1'b0;
            lex_reg.hb    <= 8'd0;
            lex_reg.opc   <= '0;
        end else if (accept) begin
            lex_reg <= lex_next;
        end
    end

endmodule

`default_nettype wire

@@ src/stl_fifo.sv @@
// Bundle queue between the lexer front end and the result serializer.
// Register-based circular buffer with occupancy count.
// Depends on stl_pkg.
`default_nettype none

module stl_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  stl_pkg::bundle_t      wr_data,
    input  wire logic             pop,
    output stl_pkg::bundle_t      head,
    output stl_pkg::q_stat_t      stat
);
    import stl_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t         buf_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;

    always_comb begin
        wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        cnt_next    = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + CW'(1);
        else if (pop && !push) cnt_next = cnt_reg - CW'(1);
        stat.full  = (cnt_reg == CW'(DEPTH));
        stat.empty = (cnt_reg == '0);
        head       = buf_reg[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (push) buf_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_next;
            if (pop)  rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ src/stl_back.sv @@
// Back end of the shell token lexer: unpacks queued bundles.
// Drives one result item per cycle from an output register while m_ready is high.
// Depends on stl_pkg.
`default_nettype none

module stl_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  stl_pkg::bundle_t      head,
    input  stl_pkg::q_stat_t      stat,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output stl_pkg::out_item_t    m_item
);
    import stl_pkg::*;

    logic [1:0] idx_reg;
    logic       valid_reg;
    out_item_t  item_reg;
    out_item_t  item_load;
    logic       load;
    logic       last;

    always_comb begin
        load = !valid_reg || m_ready;
        last = ({1'b0, idx_reg} + 3'd1) == head.cnt;
        pop  = load && !stat.empty && last;
        item_load          = head.r[idx_reg];
        item_load.run_last = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= !stat.empty;
            if (!stat.empty) idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && !stat.empty) begin
            item_reg <= item_load;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

`default_nettype wire

@@ src/shell_token_lexer.sv @@
// Shell token lexer, top level.
// Takes a command line one byte per item and streams out shell tokens.
// Input channel s_: one byte and a line_end flag per item.
// Result channel m_: one token byte (or error code) per item, tagged with
// kind, token_end and run_last (last result caused by one input item).
// Each input item causes zero to four results. The front end classifies
// the byte in the cycle it is accepted and writes its results as one
// bundle into a queue of DEPTH bundles; the back end sends them out one
// per cycle through an output register while m_ready is high.
// The first result of an item passes through the queue and then the
// output register before it is valid on m_.
// Throughput: one input item per cycle while the queue has room; the
// result side moves one item per cycle while m_ready is high, so an
// item's results leave one by one; the queue absorbs short bursts.
// When the receiver stalls, results hold on m_ and the queue fills; once
// it is full s_ready drops until a bundle leaves.
// Reset (aresetn low, synchronous) empties the queue, clears the output
// valid flag and returns the lexer to idle between tokens.
// Depends on stl_pkg, stl_front, stl_fifo, stl_back.
`default_nettype none

module shell_token_lexer #(
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  stl_pkg::in_item_t     s_item,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output stl_pkg::out_item_t    m_item
);
    import stl_pkg::*;

    bundle_t bundle;
    bundle_t head;
    q_stat_t stat;
    logic    push;
    logic    pop;
    logic    accept;

    assign s_ready = !stat.full;
    assign accept  = s_valid && s_ready;

    stl_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_item),
        .bundle  (bundle),
        .push    (push)
    );

    stl_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (bundle),
        .pop     (pop),
        .head    (head),
        .stat    (stat)
    );

    stl_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .stat    (stat),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

`default_nettype wire

@@ tb/shell_token_lexer_tb.sv @@
// Testbench for shell_token_lexer: directed table, then random command lines.
// Checks every token item against an in-bench lexer model or a typed directed row, with random idling.
// Depends on stl_pkg and the shell_token_lexer RTL.
`timescale 1ns / 100ps

module shell_token_lexer_tb;
    import stl_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 270;
    localparam out_item_t NO_TOKEN = '0;

    typedef enum logic [2:0] {
        LX_IDLE, LX_WORD, LX_TWO, LX_OP, LX_QUOTE, LX_DROP
    } lex_mode_t;

    typedef struct {
        in_item_t  it;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    lex_mode_t lx_mode;
    bit [7:0]  op_buf [3];
    int unsigned op_len;
    bit        q_single;
    bit [7:0]  held;
    bit        held_ok;

    out_item_t step_res [$];
    out_item_t tokens_due [$];
    out_item_t due_head;
    bit [7:0]  line_q [$];

    int fail_cnt;
    int items_sent;
    int tokens_checked;
    int errors_seen;
    int random_items;
    int lines_sent;
    int idle_cycles;
    bit s_burst;
    bit r_burst;
    bit noisy;
    int gap_r;
    in_item_t line_item;

    string    op_set [9] = '{";", "|", "&&", "<", "<<", ">", ">>", "2>", "2>>"};
    bit [7:0] ws_set [3] = '{CH_SPACE, CH_TAB, CH_NL};
    bit [7:0] opch_set [6] = '{CH_TWO, CH_SEMI, CH_AMP, CH_PIPE, CH_LT, CH_GT};

    dir_row_t dir_tab [28] = '{
        '{'{"a", 1'b1}, 1'b1, '{"a", 1'b1, KIND_WORD, 1'b1, ERR_NONE, 1'b1}},
        '{'{8'hff, 1'b0}, 1'b0, NO_TOKEN},
        '{'{8'h00, 1'b1}, 1'b0, NO_TOKEN},
        '{'{CH_TWO, 1'b1}, 1'b1, '{CH_TWO, 1'b1, KIND_WORD, 1'b1, ERR_NONE, 1'b1}},
        '{'{CH_TWO, 1'b0}, 1'b0, NO_TOKEN},
        '{'{CH_GT, 1'b0}, 1'b0, NO_TOKEN},
        '{'{CH_GT, 1'b0}, 1'b0, NO_TOKEN},
        '{'{"f", 1'b0}, 1'b0, NO_TOKEN},
        '{'{CH_AMP, 1'b0}, 1'b0, NO_TOKEN},
        '{'{CH_AMP, 1'b0}, 1'b0, NO_TOKEN},
        '{'{CH_TAB, 1'b0}, 1'b0, NO_TOKEN},
        '{'{CH_DQ, 1'b0}, 1'b0, NO_TOKEN},
        '{'{CH_DQ, 1'b0}, 1'b0, NO_TOKEN},
        '{'{CH_SQ, 1'b0}, 1'b0, NO_TOKEN},
        '{'{"q", 1'b0}, 1'b0, NO_TOKEN},
        '{'{CH_SQ, 1'b0}, 1'b0, NO_TOKEN},
        '{'{CH_SEMI, 1'b0}, 1'b0, NO_TOKEN},
        '{'{CH_LT, 1'b0}, 1'b0, NO_TOKEN},
        '{'{CH_LT, 1'b0}, 1'b0, NO_TOKEN},
        '{'{"z", 1'b1}, 1'b1, '{8'h00, 1'b0, KIND_WORD, 1'b1, ERR_SEP, 1'b1}},
        '{'{CH_GT, 1'b0}, 1'b0, NO_TOKEN},
        '{'{CH_GT, 1'b0}, 1'b0, NO_TOKEN},
        '{'{CH_GT, 1'b0}, 1'b0, NO_TOKEN},
        '{'{CH_GT, 1'b0}, 1'b0, NO_TOKEN},
        '{'{"w", 1'b0}, 1'b1, '{8'h00, 1'b0, KIND_WORD, 1'b1, ERR_REDIR, 1'b1}},
        '{'{"v", 1'b1}, 1'b0, NO_TOKEN},
        '{'{CH_SQ, 1'b0}, 1'b0, NO_TOKEN},
        '{'{"a", 1'b1}, 1'b1, '{8'h00, 1'b0, KIND_WORD, 1'b1, ERR_QUOTE, 1'b1}}
    };

    shell_token_lexer u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #5 aclk = ~aclk;

    function automatic bit is_ws(bit [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL;
    endfunction

    function automatic bit is_sep(bit [7:0] c);
        return c == CH_SEMI || c == CH_AMP || c == CH_PIPE;
    endfunction

    function automatic bit is_redir(bit [7:0] c);
        return c == CH_LT || c == CH_GT;
    endfunction

    function automatic bit is_opch(bit [7:0] c);
        return c == CH_TWO || is_sep(c) || is_redir(c);
    endfunction

    function automatic bit is_stop(bit [7:0] c);
        return is_ws(c) || is_sep(c) || is_redir(c);
    endfunction

    function automatic void emit(bit [7:0] b, bit has, logic [3:0] kind, bit endf,
                                 logic [1:0] err);
        out_item_t r;
        r = '{b, has, kind, endf, err, 1'b0};
        step_res.push_back(r);
    endfunction

    // Judge a finished operator run; emit its bytes or an error code.
    function automatic bit close_run();
        logic [3:0] kind;
        logic [1:0] err;
        int unsigned n;
        kind = KIND_WORD;
        err = ERR_NONE;
        n = op_len;
        if (is_sep(op_buf[0])) begin
            if (n == 1 && op_buf[0] != CH_AMP) kind = KIND_SEP;
            else if (n == 2 && op_buf[0] == CH_AMP && op_buf[1] == CH_AMP) kind = KIND_SEP;
            else err = ERR_SEP;
        end else if (n == 1 && op_buf[0] == CH_LT) kind = KIND_IN;
        else if (n == 2 && op_buf[0] == CH_LT && op_buf[1] == CH_LT) kind = KIND_IN;
        else if (n == 1 && op_buf[0] == CH_GT) kind = KIND_OUT;
        else if (n == 2 && op_buf[0] == CH_GT && op_buf[1] == CH_GT) kind = KIND_APPEND;
        else if (n == 2 && op_buf[0] == CH_TWO && op_buf[1] == CH_GT) kind = KIND_ERR_OUT;
        else if (n == 3 && op_buf[0] == CH_TWO && op_buf[1] == CH_GT && op_buf[2] == CH_GT)
            kind = KIND_ERR_APPEND;
        else err = ERR_REDIR;
        op_len = 0;
        if (err != ERR_NONE) begin
            emit(8'h00, 1'b0, KIND_WORD, 1'b1, err);
            lx_mode = LX_DROP;
            return 1'b0;
        end
        for (int i = 0; i < n && i < 3; i++)
            emit(op_buf[i], 1'b1, kind, i + 1 == n, ERR_NONE);
        lx_mode = LX_IDLE;
        return 1'b1;
    endfunction

    function automatic void begin_token(bit [7:0] c);
        if (is_ws(c)) begin
            lx_mode = LX_IDLE;
        end else if (c == CH_DQ || c == CH_SQ) begin
            lx_mode = LX_QUOTE;
            q_single = (c == CH_SQ);
            held_ok = 1'b0;
        end else if (c == CH_TWO) begin
            lx_mode = LX_TWO;
        end else if (is_opch(c)) begin
            lx_mode = LX_OP;
            op_buf[0] = c;
            op_len = 1;
        end else begin
            lx_mode = LX_WORD;
            held = c;
        end
    endfunction

    function automatic void word_byte(bit [7:0] c);
        if (is_stop(c)) begin
            emit(held, 1'b1, KIND_WORD, 1'b1, ERR_NONE);
            begin_token(c);
        end else begin
            emit(held, 1'b1, KIND_WORD, 1'b0, ERR_NONE);
            held = c;
        end
    endfunction

    // Advance the lexer model by one item; leave its tokens in step_res.
    function automatic void lex_step(in_item_t it);
        bit [7:0]   c;
        bit [7:0]   closer;
        logic [3:0] qk;
        out_item_t  r;
        c = it.in_byte;
        closer = q_single ? CH_SQ : CH_DQ;
        qk = q_single ? KIND_SQUOTE : KIND_DQUOTE;
        step_res.delete();
        case (lx_mode)
            LX_WORD: word_byte(c);
            LX_TWO: begin
                if (is_redir(c)) begin
                    lx_mode = LX_OP;
                    op_buf[0] = CH_TWO;
                    op_buf[1] = c;
                    op_len = 2;
                end else begin
                    lx_mode = LX_WORD;
                    held = CH_TWO;
                    word_byte(c);
                end
            end
            LX_OP: begin
                if (is_opch(c)) begin
                    if (op_len < 3) op_buf[op_len] = c;
                    if (op_len < 4) op_len++;
                end else if (close_run()) begin
                    begin_token(c);
                end
            end
            LX_QUOTE: begin
                if (c == closer) begin
                    emit(held_ok ? held : 8'h00, held_ok, qk, 1'b1, ERR_NONE);
                    held_ok = 1'b0;
                    lx_mode = LX_IDLE;
                end else begin
                    if (held_ok) emit(held, 1'b1, qk, 1'b0, ERR_NONE);
                    held = c;
                    held_ok = 1'b1;
                end
            end
            LX_DROP: ;
            default: begin_token(c);
        endcase
        if (it.line_end) begin
            case (lx_mode)
                LX_WORD:  emit(held, 1'b1, KIND_WORD, 1'b1, ERR_NONE);
                LX_TWO:   emit(CH_TWO, 1'b1, KIND_WORD, 1'b1, ERR_NONE);
                LX_OP:    void'(close_run());
                LX_QUOTE: emit(8'h00, 1'b0, KIND_WORD, 1'b1, ERR_QUOTE);
                default:  ;
            endcase
            lx_mode = LX_IDLE;
            op_len = 0;
            held_ok = 1'b0;
        end
        if (step_res.size() > 0) begin
            r = step_res.pop_back();
            r.run_last = 1'b1;
            step_res.push_back(r);
        end
    endfunction

    function automatic bit [7:0] word_char(bit lead);
        bit [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (is_stop(b) || (lead && (b == CH_DQ || b == CH_SQ)));
        return b;
    endfunction

    // Build one command line: mostly valid tokens, sometimes broken input.
    task automatic build_line(output bit broken);
        string    op;
        bit [7:0] q;
        bit [7:0] b;
        line_q.delete();
        broken = ($urandom_range(0, 5) == 0);
        if (broken) begin
            case ($urandom_range(0, 2))
                0: repeat ($urandom_range(2, 4)) line_q.push_back(opch_set[$urandom_range(0, 5)]);
                1: begin
                    line_q.push_back($urandom_range(0, 1) ? CH_DQ : CH_SQ);
                    repeat ($urandom_range(0, 3)) line_q.push_back(8'($urandom_range(0, 255)));
                end
                default: repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end else begin
            if ($urandom_range(0, 3) == 0) line_q.push_back(ws_set[$urandom_range(0, 2)]);
            repeat ($urandom_range(1, 5)) begin
                case ($urandom_range(0, 2))
                    0: begin
                        line_q.push_back(word_char(1'b1));
                        repeat ($urandom_range(0, 3)) line_q.push_back(word_char(1'b0));
                    end
                    1: begin
                        op = op_set[$urandom_range(0, 8)];
                        for (int i = 0; i < op.len(); i++) line_q.push_back(op[i]);
                    end
                    default: begin
                        q = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
                        line_q.push_back(q);
                        repeat ($urandom_range(0, 3)) begin
                            do b = 8'($urandom_range(0, 255));
                            while (b == q);
                            line_q.push_back(b);
                        end
                        line_q.push_back(q);
                    end
                endcase
                if ($urandom_range(0, 2) != 0) line_q.push_back(ws_set[$urandom_range(0, 2)]);
            end
        end
    endtask

    // Drive one item, hold it until accepted, then queue its expected tokens.
    task automatic send_item(in_item_t it, bit typed, out_item_t want);
        int gap;
        gap = s_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        lex_step(it);
        if (typed) tokens_due.push_back(want);
        else foreach (step_res[i]) tokens_due.push_back(step_res[i]);
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (tokens_due.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %h", $time, m_item);
                fail_cnt++;
            end else begin
                due_head = tokens_due.pop_front();
                check_field("out_byte", due_head.out_byte, m_item.out_byte);
                check_field("has_byte", 8'(due_head.has_byte), 8'(m_item.has_byte));
                check_field("token_kind", 8'(due_head.token_kind), 8'(m_item.token_kind));
                check_field("token_end", 8'(due_head.token_end), 8'(m_item.token_end));
                check_field("error_code", 8'(due_head.error_code), 8'(m_item.error_code));
                check_field("run_last", 8'(due_head.run_last), 8'(m_item.run_last));
                tokens_checked++;
                if (due_head.error_code != ERR_NONE) errors_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        r_burst = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 15) == 0) r_burst = !r_burst;
            gap_r = r_burst ? 0 : $urandom_range(0, 7);
            if (gap_r > 0) begin
                m_ready <= 1'b0;
                repeat (gap_r) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin
        s_valid = 1'b0;
        s_item = '0;
        aresetn = 1'b0;
        s_burst = 1'b0;
        lx_mode = LX_IDLE;
        op_buf = '{8'h00, 8'h00, 8'h00};
        op_len = 0;
        q_single = 1'b0;
        held = 8'h00;
        held_ok = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);

        while (random_items < RANDOM_ITEMS) begin
            build_line(noisy);
            s_burst = ($urandom_range(0, 3) == 0);
            foreach (line_q[i]) begin
                line_item.in_byte = line_q[i];
                line_item.line_end = (i == line_q.size() - 1);
                send_item(line_item, 1'b0, NO_TOKEN);
            end
            random_items += line_q.size();
            lines_sent++;
        end
        s_valid <= 1'b0;

        while (tokens_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d bytes (%0d directed, %0d random lines), checked %0d token items,",
                 items_sent, $size(dir_tab), lines_sent, tokens_checked);
        $display("%0d of them error codes; %0d mismatches.", errors_seen, fail_cnt);
        if (fail_cnt == 0 && tokens_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
